// ----- hdl/gks_pkg.sv -----
// Shared package for the grid kernel smoothing block.
// Holds the grid geometry, field widths, kernel tables and the control
// types passed between the controller and the datapath. No dependencies.
package gks_pkg;

    // Grid geometry.
    localparam int MAX_X      = 64;
    localparam int MAX_Y      = 64;
    localparam int GRID_DEPTH = MAX_X * MAX_Y;
    localparam int ADDR_W     = $clog2(GRID_DEPTH);

    // Field widths.
    localparam int CELL_W     = 6;
    localparam int COUNT_W    = 16;
    localparam int SIZE_W     = 7;
    localparam int MODE_W     = 3;
    localparam int SUM_W      = 22;
    localparam int NORM_W     = 6;
    localparam int WEIGHT_W   = 4;
    localparam int PROD_W     = COUNT_W + WEIGHT_W;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Kernel window.
    localparam int TAPS    = 5;
    localparam int TAP_W   = 3;
    localparam int TAP_OFF = 2;

    localparam logic [TAP_W-1:0]  TAP_LAST = TAP_W'(TAPS - 1);
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(GRID_DEPTH - 1);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd2;

    // Kernel modes; codes above MODE_NONE behave as MODE_NONE.
    localparam logic [MODE_W-1:0] MODE_K5A  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_NONE = 3'd4;

    // Input command codes (carried on tuser).
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef logic [WEIGHT_W-1:0] kern_tab_t [TAPS][TAPS][TAPS];
    typedef logic [NORM_W-1:0]   norm_tab_t [TAPS];

    // Weights indexed by mode, first-axis offset, second-axis offset.
    // The 3x3 kernels sit in the middle of a zero border.
    localparam kern_tab_t KERN_TAB = '{
        '{ '{0, 0, 1, 0, 0}, '{0, 2, 2, 2, 0}, '{1, 2, 5, 2, 1},
           '{0, 2, 2, 2, 0}, '{0, 0, 1, 0, 0} },
        '{ '{0, 1, 2, 1, 0}, '{1, 2, 4, 2, 1}, '{2, 4, 8, 4, 2},
           '{1, 2, 4, 2, 1}, '{0, 1, 2, 1, 0} },
        '{ '{0, 0, 0, 0, 0}, '{0, 0, 1, 0, 0}, '{0, 1, 2, 1, 0},
           '{0, 0, 1, 0, 0}, '{0, 0, 0, 0, 0} },
        '{ '{0, 0, 0, 0, 0}, '{0, 1, 2, 1, 0}, '{0, 2, 4, 2, 0},
           '{0, 1, 2, 1, 0}, '{0, 0, 0, 0, 0} },
        '{ '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}, '{0, 0, 1, 0, 0},
           '{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0} }
    };

    localparam norm_tab_t NORM_TAB = '{25, 48, 6, 16, 1};

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } gks_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              clear_en;
        logic [ADDR_W-1:0] clear_addr;
        logic              load_en;
        logic              start;
        logic              tap_en;
        logic [TAP_W-1:0]  tap_n;
        logic [TAP_W-1:0]  tap_k;
        logic              out_load;
    } gks_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } gks_stat_t;

    // A size above the grid acts as the grid's extent.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] size,
                                                   input int               max_cells);
        logic [SIZE_W-1:0] res;
        res = (int'(size) > max_cells) ? SIZE_W'(max_cells) : size;
        return res;
    endfunction

    function automatic logic [MODE_W-1:0] mode_sel(input logic [MODE_W-1:0] mode);
        logic [MODE_W-1:0] res;
        res = (mode > MODE_NONE) ? MODE_NONE : mode;
        return res;
    endfunction

endpackage

// ----- hdl/grid_kernel_smoothing.sv -----
// Top level of the grid kernel smoothing block.
// Depends on gks_pkg, gks_ctrl, gks_datapath (and through it gks_ram).
//
// The block keeps a 64 x 64 grid of 16-bit counts in a single-port memory.
// A load word writes one cell and leaves the block idle; a load outside the
// configured size is dropped and gives no result. A read word returns the
// unnormalized weighted sum of the cell and its neighbors under the selected
// kernel, together with the kernel's norm; neighbors outside the configured
// size count as zero, and a read outside the size returns zero with the
// address error flag set. A read walks all 25 positions of a 5x5 window,
// one memory read and one multiply-accumulate per cycle, and no input word
// is taken until its result is in the output register; the single memory
// port keeps reads from overlapping. A finished result waits in an output
// register, so the block takes the next word while the previous result is
// still unclaimed. After reset the block clears all 4096 grid cells, one cell
// per cycle, and takes no word until it finishes. Configuration writes are
// taken in any cycle (cfg_ready is always high) but should be issued only
// while the block is idle. Register 0 is size_x, 1 is size_y, 2 is the kernel
// mode (0 5x5a, 1 5x5b, 2 3x3a, 3 3x3 Gaussian, 4 and above pass-through).
module grid_kernel_smoothing import gks_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,

    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // cell_x[5:0], cell_y[11:6], count[27:12]
    input  logic                  s_tuser,   // command: 0 load, 1 read

    // Result stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // smoothed[21:0], kernel_norm[27:22]
    output logic                  m_tuser,   // address_error

    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int X_LO = 0;
    localparam int Y_LO = X_LO + CELL_W;
    localparam int C_LO = Y_LO + CELL_W;
    localparam int S_USED = C_LO + COUNT_W;
    localparam int M_USED = SUM_W + NORM_W;

    gks_cmd_t           cmd;
    gks_stat_t          stat;
    logic [CELL_W-1:0]  in_cell_x, in_cell_y;
    logic [COUNT_W-1:0] in_count;
    logic [SUM_W-1:0]   out_smoothed;
    logic [NORM_W-1:0]  out_kernel_norm;
    logic               out_address_error;
    logic               out_valid;

    assign in_cell_x = s_tdata[X_LO +: CELL_W];
    assign in_cell_y = s_tdata[Y_LO +: CELL_W];
    assign in_count  = s_tdata[C_LO +: COUNT_W];

    // Configuration registers accept a word in every cycle.
    assign cfg_ready = 1'b1;

    gks_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_read   (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gks_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_cell_x         (in_cell_x),
        .in_cell_y         (in_cell_y),
        .in_count          (in_count),
        .cmd               (cmd),
        .stat              (stat),
        .m_tready          (m_tready),
        .out_valid         (out_valid),
        .out_smoothed      (out_smoothed),
        .out_kernel_norm   (out_kernel_norm),
        .out_address_error (out_address_error)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {{(M_TDATA_W - M_USED){1'b0}}, out_kernel_norm, out_smoothed};
    assign m_tuser  = out_address_error;

    // Upper input bits beyond the count are padding and are not used.
    logic s_pad_unused;
    assign s_pad_unused = ^s_tdata[S_TDATA_W-1:S_USED];

endmodule

// ----- hdl/gks_ram.sv -----
// Generic single-port RAM with registered read data.
// Used for the cell count grid; no dependencies.
module gks_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- hdl/gks_ctrl.sv -----
// Controller for the grid kernel smoothing block: clearing pass after reset,
// input handshake and the 5x5 tap sequencer. Depends on gks_pkg.
module gks_ctrl import gks_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    input  logic      s_read,
    output logic      s_tready,
    input  gks_stat_t stat,
    output gks_cmd_t  cmd
);

    gks_state_t        state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [TAP_W-1:0]  tap_n_reg, tap_n_next;
    logic [TAP_W-1:0]  tap_k_reg, tap_k_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            tap_n_reg   <= '0;
            tap_k_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            tap_n_reg   <= tap_n_next;
            tap_k_reg   <= tap_k_next;
        end
    end

    always_comb begin
        logic accept;
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        tap_n_next   = tap_n_reg;
        tap_k_next   = tap_k_reg;
        s_tready     = 1'b0;
        accept       = 1'b0;
        cmd          = '0;
        cmd.clear_addr = clr_cnt_reg;
        cmd.tap_n      = tap_n_reg;
        cmd.tap_k      = tap_k_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_en = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready    = 1'b1;
                accept      = s_tvalid;
                cmd.load_en = accept && (s_read == CMD_LOAD);
                cmd.start   = accept && (s_read == CMD_READ);
                if (cmd.start) begin
                    tap_n_next = '0;
                    tap_k_next = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.tap_en = 1'b1;
                if (tap_k_reg == TAP_LAST) begin
                    tap_k_next = '0;
                    if (tap_n_reg == TAP_LAST) begin
                        tap_n_next = '0;
                        state_next = ST_DRAIN;
                    end else begin
                        tap_n_next = tap_n_reg + 1'b1;
                    end
                end else begin
                    tap_k_next = tap_k_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The clearing pass runs to its last address before any word is taken.
    a_clear_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR && clr_cnt_reg != CLR_LAST) |=> state_reg == ST_CLEAR)
        else $error("clearing pass left early");

    a_tap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (tap_n_reg <= TAP_LAST) && (tap_k_reg <= TAP_LAST))
        else $error("tap counter out of window");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded over a waiting result");

    a_start_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> state_reg == ST_SCAN)
        else $error("read did not enter the scan");

endmodule

// ----- hdl/gks_datapath.sv -----
// Datapath for the grid kernel smoothing block: configuration registers,
// cell grid memory, tap address generation, multiply-accumulate and the
// output register. Depends on gks_pkg and gks_ram.
module gks_datapath import gks_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [CELL_W-1:0]     in_cell_x,
    input  logic [CELL_W-1:0]     in_cell_y,
    input  logic [COUNT_W-1:0]    in_count,
    input  gks_cmd_t              cmd,
    output gks_stat_t             stat,
    input  logic                  m_tready,
    output logic                  out_valid,
    output logic [SUM_W-1:0]      out_smoothed,
    output logic [NORM_W-1:0]     out_kernel_norm,
    output logic                  out_address_error
);

    logic [SIZE_W-1:0]  size_x_reg, size_y_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic [SIZE_W-1:0]  sx_eff, sy_eff;
    logic [MODE_W-1:0]  mode_eff;

    logic [CELL_W-1:0]  item_x_reg, item_y_reg;
    logic               item_inside_reg;
    logic               in_inside;

    logic [CELL_W:0]    xe, ye, xb, yb;
    logic               tap_ok;
    logic [ADDR_W-1:0]  load_addr, tap_addr, ram_addr;
    logic               ram_we;
    logic [COUNT_W-1:0] ram_wdata, ram_rdata;

    logic [WEIGHT_W-1:0] w_reg, w_next;
    logic                mac_valid_reg;
    logic [PROD_W-1:0]   product;
    logic [SUM_W-1:0]    acc_reg, acc_next;

    logic               out_valid_reg;
    logic [SUM_W-1:0]   out_sum_reg;
    logic [NORM_W-1:0]  out_norm_reg;
    logic               out_err_reg;

    assign sx_eff   = eff_size(size_x_reg, MAX_X);
    assign sy_eff   = eff_size(size_y_reg, MAX_Y);
    assign mode_eff = mode_sel(mode_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg <= SIZE_W'(MAX_X);
            size_y_reg <= SIZE_W'(MAX_Y);
            mode_reg   <= MODE_K5A;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SIZE_X: size_x_reg <= cfg_data;
                CFG_SIZE_Y: size_y_reg <= cfg_data;
                CFG_MODE:   mode_reg   <= cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Incoming word: range check and grid address for a load.
    assign in_inside = ({1'b0, in_cell_x} < sx_eff) && ({1'b0, in_cell_y} < sy_eff);
    assign load_addr = ADDR_W'(in_cell_x) + ADDR_W'(ADDR_W'(in_cell_y) * ADDR_W'(MAX_X));

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            item_x_reg      <= in_cell_x;
            item_y_reg      <= in_cell_y;
            item_inside_reg <= in_inside;
        end
    end

    // Neighbor position for the current tap, offset by the window center.
    assign xe = {1'b0, item_x_reg} + (CELL_W + 1)'(cmd.tap_n);
    assign ye = {1'b0, item_y_reg} + (CELL_W + 1)'(cmd.tap_k);
    assign xb = xe - (CELL_W + 1)'(TAP_OFF);
    assign yb = ye - (CELL_W + 1)'(TAP_OFF);
    assign tap_ok = item_inside_reg
                 && (xe >= (CELL_W + 1)'(TAP_OFF)) && (xb < sx_eff)
                 && (ye >= (CELL_W + 1)'(TAP_OFF)) && (yb < sy_eff);
    assign tap_addr = ADDR_W'(xb) + ADDR_W'(ADDR_W'(yb) * ADDR_W'(MAX_X));

    always_comb begin
        ram_we    = cmd.clear_en || (cmd.load_en && in_inside);
        ram_wdata = cmd.clear_en ? '0 : in_count;
        if (cmd.clear_en) begin
            ram_addr = cmd.clear_addr;
        end else if (cmd.load_en) begin
            ram_addr = load_addr;
        end else begin
            ram_addr = tap_addr;
        end
    end

    gks_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (GRID_DEPTH)
    ) u_grid (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // The weight is registered so that it arrives together with the registered read data.
    assign w_next  = tap_ok ? KERN_TAB[mode_eff][cmd.tap_n][cmd.tap_k] : '0;
    assign product = PROD_W'(w_reg) * PROD_W'(ram_rdata);

    always_comb begin
        acc_next = acc_reg;
        if (cmd.start) begin
            acc_next = '0;
        end else if (mac_valid_reg) begin
            acc_next = acc_reg + SUM_W'(product);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mac_valid_reg <= 1'b0;
        end else begin
            mac_valid_reg <= cmd.tap_en;
        end
    end

    always_ff @(posedge aclk) begin
        w_reg   <= w_next;
        acc_reg <= acc_next;
    end

    // Output register: holds a finished result until it is taken.
    assign stat.out_free = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_sum_reg  <= acc_reg;
            out_norm_reg <= NORM_TAB[mode_eff];
            out_err_reg  <= !item_inside_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_smoothed      = out_sum_reg;
    assign out_kernel_norm   = out_norm_reg;
    assign out_address_error = out_err_reg;

endmodule
